// File: src/a2dk_pkg.sv
// Shared types and constants for the axis-to-direction-keys block.
package a2dk_pkg;

  localparam int KEY_CODE_W  = 7;
  localparam int KEY_EVENT_W = 8;
  localparam int QUAL_W      = 16;
  localparam int AXIS_W      = 16;
  localparam int MAG_W       = AXIS_W + 1;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = 2;
  localparam int FIFO_CNT_W  = 3;

  // Direction index into the key code and mask tables
  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_t;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_UP_CODE    = 3'd0,
    REG_DOWN_CODE  = 3'd1,
    REG_LEFT_CODE  = 3'd2,
    REG_RIGHT_CODE = 3'd3,
    REG_UP_MASK    = 3'd4,
    REG_DOWN_MASK  = 3'd5,
    REG_LEFT_MASK  = 3'd6,
    REG_RIGHT_MASK = 3'd7
  } cfg_reg_t;

  // Axis select codes
  localparam logic AXIS_HORIZONTAL = 1'b0;
  localparam logic AXIS_VERTICAL   = 1'b1;

  localparam logic KEY_PRESS   = 1'b0;
  localparam logic KEY_RELEASE = 1'b1;

  // One result item
  typedef struct packed {
    logic                   last;
    logic [QUAL_W-1:0]      qualifier;
    logic [KEY_EVENT_W-1:0] key_event;
  } res_t;

  // Results produced by one input item, pushed into the output queue
  typedef struct packed {
    logic [1:0]      n;
    res_t [1:0]      res;
  } push_t;

  typedef logic [3:0][KEY_CODE_W-1:0] code_tbl_t;
  typedef logic [3:0][QUAL_W-1:0]     mask_tbl_t;

endpackage

// File: src/a2dk_cfg_regs.sv
// Configuration registers: key codes and qualifier masks per direction.
module a2dk_cfg_regs
  import a2dk_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output code_tbl_t              key_code,
  output mask_tbl_t              qual_mask
);

  assign cfg_ready = 1'b1;

  // Register write decode
  always_ff @(posedge clk) begin
    if (rst) begin
      key_code  <= '0;
      qual_mask <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_UP_CODE:    key_code[DIR_UP]    <= cfg_data[KEY_CODE_W-1:0];
        REG_DOWN_CODE:  key_code[DIR_DOWN]  <= cfg_data[KEY_CODE_W-1:0];
        REG_LEFT_CODE:  key_code[DIR_LEFT]  <= cfg_data[KEY_CODE_W-1:0];
        REG_RIGHT_CODE: key_code[DIR_RIGHT] <= cfg_data[KEY_CODE_W-1:0];
        REG_UP_MASK:    qual_mask[DIR_UP]    <= cfg_data[QUAL_W-1:0];
        REG_DOWN_MASK:  qual_mask[DIR_DOWN]  <= cfg_data[QUAL_W-1:0];
        REG_LEFT_MASK:  qual_mask[DIR_LEFT]  <= cfg_data[QUAL_W-1:0];
        REG_RIGHT_MASK: qual_mask[DIR_RIGHT] <= cfg_data[QUAL_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: src/a2dk_core.sv
// Input register, peak tracking, direction decision and key state.
module a2dk_core
  import a2dk_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [AXIS_W-1:0] s_tdata,   // [15:0] axis_value
  input  logic              s_tuser,   // [0] axis_select
  input  logic              space_ok,
  input  code_tbl_t         key_code,
  input  mask_tbl_t         qual_mask,
  output push_t             push
);

  // Input register
  logic              in_valid;
  logic              in_sel;
  logic [AXIS_W-1:0] in_value;
  logic [MAG_W-1:0]  in_mag;
  logic [MAG_W-1:0]  s_val_ext;
  logic [MAG_W-1:0]  s_mag;
  logic              fire;

  // Block state
  logic [AXIS_W-1:0] peak;
  logic [AXIS_W-1:0] peak_next;
  logic [3:0]        held;
  logic [3:0]        held_next;
  logic [QUAL_W-1:0] qual;
  logic [QUAL_W-1:0] qual_next;

  logic                centred;
  logic [AXIS_W-2:0]   half;
  logic                neg;
  dir_t                press_dir;
  dir_t                rel_a;
  dir_t                rel_b;
  logic [KEY_CODE_W-1:0] press_code;
  logic [QUAL_W-1:0]     press_mask;
  logic [KEY_CODE_W-1:0] code_a;
  logic [KEY_CODE_W-1:0] code_b;
  logic [QUAL_W-1:0]     mask_a;
  logic [QUAL_W-1:0]     mask_b;
  logic [QUAL_W-1:0]     q1;
  logic [QUAL_W-1:0]     q2;
  push_t                 res_set;

  // Magnitude of the incoming sample, 17 bits so -32768 fits
  assign s_val_ext = {s_tdata[AXIS_W-1], s_tdata};
  assign s_mag     = s_val_ext[MAG_W-1] ? (~s_val_ext + MAG_W'(1)) : s_val_ext;

  assign fire     = in_valid && space_ok;
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_sel   <= s_tuser;
      in_value <= s_tdata;
      in_mag   <= s_mag;
    end
  end

  // Peak update and centre band test
  assign peak_next = (in_mag > {1'b0, peak}) ? in_mag[AXIS_W-1:0] : peak;
  assign half      = peak_next[AXIS_W-1:1];
  assign centred   = (in_mag == '0) || (in_mag < {2'b00, half});
  assign neg       = in_value[AXIS_W-1];

  // Direction and table selection
  always_comb begin
    if (in_sel == AXIS_VERTICAL) begin
      press_dir = neg ? DIR_UP : DIR_DOWN;
      rel_a     = DIR_UP;
      rel_b     = DIR_DOWN;
      code_a    = key_code[DIR_UP];
      code_b    = key_code[DIR_DOWN];
      mask_a    = qual_mask[DIR_UP];
      mask_b    = qual_mask[DIR_DOWN];
    end else begin
      press_dir = neg ? DIR_LEFT : DIR_RIGHT;
      rel_a     = DIR_LEFT;
      rel_b     = DIR_RIGHT;
      code_a    = key_code[DIR_LEFT];
      code_b    = key_code[DIR_RIGHT];
      mask_a    = qual_mask[DIR_LEFT];
      mask_b    = qual_mask[DIR_RIGHT];
    end
  end

  always_comb begin
    unique case (press_dir)
      DIR_UP: begin
        press_code = key_code[DIR_UP];
        press_mask = qual_mask[DIR_UP];
      end
      DIR_DOWN: begin
        press_code = key_code[DIR_DOWN];
        press_mask = qual_mask[DIR_DOWN];
      end
      DIR_LEFT: begin
        press_code = key_code[DIR_LEFT];
        press_mask = qual_mask[DIR_LEFT];
      end
      DIR_RIGHT: begin
        press_code = key_code[DIR_RIGHT];
        press_mask = qual_mask[DIR_RIGHT];
      end
      default: begin
        press_code = '0;
        press_mask = '0;
      end
    endcase
  end

  // Qualifier after each release in order
  assign q1 = held[rel_a] ? (qual & ~mask_a) : qual;
  assign q2 = held[rel_b] ? (q1 & ~mask_b) : q1;

  // Press or release results and next key state
  always_comb begin
    res_set   = '0;
    held_next = held;
    qual_next = qual;
    if (!centred) begin
      if (!held[press_dir]) begin
        qual_next              = qual | press_mask;
        held_next[press_dir]   = 1'b1;
        res_set.n              = 2'd1;
        res_set.res[0].key_event = {KEY_PRESS, press_code};
        res_set.res[0].qualifier = qual | press_mask;
        res_set.res[0].last      = 1'b1;
      end
    end else begin
      held_next[rel_a] = 1'b0;
      held_next[rel_b] = 1'b0;
      qual_next        = q2;
      if (held[rel_a] && held[rel_b]) begin
        res_set.n                = 2'd2;
        res_set.res[0].key_event = {KEY_RELEASE, code_a};
        res_set.res[0].qualifier = q1;
        res_set.res[0].last      = 1'b0;
        res_set.res[1].key_event = {KEY_RELEASE, code_b};
        res_set.res[1].qualifier = q2;
        res_set.res[1].last      = 1'b1;
      end else if (held[rel_a]) begin
        res_set.n                = 2'd1;
        res_set.res[0].key_event = {KEY_RELEASE, code_a};
        res_set.res[0].qualifier = q1;
        res_set.res[0].last      = 1'b1;
      end else if (held[rel_b]) begin
        res_set.n                = 2'd1;
        res_set.res[0].key_event = {KEY_RELEASE, code_b};
        res_set.res[0].qualifier = q2;
        res_set.res[0].last      = 1'b1;
      end
    end
  end

  always_comb begin
    push = res_set;
    if (!fire) begin
      push.n = 2'd0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      peak <= '0;
      held <= '0;
      qual <= '0;
    end else if (fire) begin
      peak <= peak_next;
      held <= held_next;
      qual <= qual_next;
    end
  end

`ifndef SYNTHESIS
  // A centred vertical sample leaves neither vertical key held
  a_vert_release: assert property (@(posedge clk) disable iff (rst)
    fire && centred && (in_sel == AXIS_VERTICAL) |=> !held[DIR_UP] && !held[DIR_DOWN])
    else $error("vertical keys still held after centring");

  // Two results only come from a double release
  a_two_is_release: assert property (@(posedge clk) disable iff (rst)
    (push.n == 2'd2) |-> centred)
    else $error("two results pushed for a pressed direction");

  // Peak never decreases
  a_peak_mono: assert property (@(posedge clk) disable iff (rst)
    fire |=> peak >= $past(peak))
    else $error("peak magnitude decreased");

  // Key state only moves on a processed item
  a_held_stable: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(held) && $stable(qual))
    else $error("key state changed without a transaction");
`endif

endmodule

// File: src/a2dk_out_fifo.sv
// Four-entry result queue: takes up to two results a cycle, gives one while m_tready is high.
module a2dk_out_fifo
  import a2dk_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  push_t                  push,
  output logic                   space_ok,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [QUAL_W+KEY_EVENT_W-1:0] m_tdata,  // [7:0] key_event, [23:8] qualifier
  output logic                   m_tlast
);

  res_t                  entry [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;
  logic [FIFO_CNT_W-1:0] count_next;
  logic                  pop;
  res_t                  head;

  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (count != '0);
  // Room for the largest burst one item can produce
  assign space_ok = (count <= FIFO_CNT_W'(FIFO_DEPTH - 2));

  assign count_next = count + FIFO_CNT_W'(push.n) - FIFO_CNT_W'(pop);

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_W'(push.n);
      rd_ptr <= rd_ptr + FIFO_PTR_W'(pop);
      count  <= count_next;
    end
  end

  // Entry writes
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      entry[wr_ptr] <= push.res[0];
    end
    if (push.n == 2'd2) begin
      entry[wr_ptr + FIFO_PTR_W'(1)] <= push.res[1];
    end
  end

  assign head    = entry[rd_ptr];
  assign m_tdata = {head.qualifier, head.key_event};
  assign m_tlast = head.last;

`ifndef SYNTHESIS
  // Queue never overflows
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  // Pushes only land when the space check allowed them
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push.n != 2'd0) |-> space_ok)
    else $error("push into a full result queue");

  // No burst larger than two
  a_push_size: assert property (@(posedge clk) disable iff (rst)
    push.n != 2'd3)
    else $error("illegal push size");
`endif

endmodule

// File: src/axis_to_direction_keys_unit.sv
// Top level of the axis-to-direction-keys block.
// Turns joystick axis samples (s_tdata = signed value, s_tuser = 0 horizontal,
// 1 vertical) into key press and release transactions carrying a key event
// and the qualifier word. One sample is taken per cycle while the four-entry
// result queue has room for two more results; a sample waits in the input
// register until then; its results go into the queue and are offered on the
// master side from there. A sample yields zero, one or two results (two when
// centring releases both keys of an axis), and the master port gives one result
// per cycle while m_tready is high, so the output port sets the sustained rate.
// The user writes key codes and masks on the cfg port, one register per
// transaction, while the block is idle; the block does not enforce this.
module axis_to_direction_keys_unit
  import a2dk_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // Sample stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [AXIS_W-1:0]      s_tdata,   // [15:0] axis_value
  input  logic                   s_tuser,   // [0] axis_select
  // Key event stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [QUAL_W+KEY_EVENT_W-1:0] m_tdata,  // [7:0] key_event, [23:8] qualifier
  output logic                   m_tlast,
  // Configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  code_tbl_t key_code;
  mask_tbl_t qual_mask;
  push_t     push;
  logic      space_ok;

  a2dk_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key_code  (key_code),
    .qual_mask (qual_mask)
  );

  a2dk_core u_core (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .space_ok  (space_ok),
    .key_code  (key_code),
    .qual_mask (qual_mask),
    .push      (push)
  );

  a2dk_out_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .space_ok (space_ok),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
